### rtl/core/rauc_pkg.sv
package rauc_pkg;

    localparam int CNT_W   = 25;
    localparam int AREA_W  = 50;
    localparam int Q_W     = 17;
    localparam int LBL_W   = 8;
    localparam int DEN_W   = 51;
    localparam int NUM_W   = 51;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(24'hFFFFFF) + CNT_W'(1);
    localparam logic [Q_W-1:0]   Q16_ONE  = 17'h10000;

    // ratio selects for the shared divider, in issue order
    localparam logic [2:0] SEL_ACC = 3'd0;
    localparam logic [2:0] SEL_PRE = 3'd1;
    localparam logic [2:0] SEL_REC = 3'd2;
    localparam logic [2:0] SEL_F1  = 3'd3;
    localparam logic [2:0] SEL_AUC = 3'd4;

    typedef enum logic [0:0]
    {
        REG_PPC   = 1'b0,
        REG_LABEL = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [31:0]      score;
        logic [LBL_W-1:0] item_label;
        logic             is_last;
    } in_item_t;

    typedef struct packed
    {
        logic [CNT_W-1:0] true_pos;
        logic [CNT_W-1:0] true_neg;
        logic [CNT_W-1:0] false_pos;
        logic [CNT_W-1:0] false_neg;
        logic [CNT_W-1:0] item_total;
        logic [Q_W-1:0]   accuracy_q16;
        logic [Q_W-1:0]   precision_q16;
        logic [Q_W-1:0]   recall_q16;
        logic [Q_W-1:0]   f1_q16;
        logic [Q_W-1:0]   auc_q16;
        logic             status;
    } out_item_t;

    // controller -> datapath
    typedef struct packed
    {
        logic       count;      // take the accepted item into the counters
        logic       close;      // close final ROC point
        logic       den_mul;    // form AUC denominator
        logic       div_start;  // load divider with ratio sel
        logic [2:0] div_sel;
        logic       div_step;
        logic       div_store;
        logic       clear;
    } dp_cmd_t;

    typedef struct packed
    {
        logic is_last;
    } dp_sts_t;

endpackage

### rtl/core/rauc_datapath.sv
module rauc_datapath
    import rauc_pkg::*;
#(
    parameter int SCORE_BITS = 32,
    parameter int MAX_ITEMS  = 16777216
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         in_item,
    input  logic [CNT_W-1:0] ppc,
    input  logic [LBL_W-1:0] pos_label,
    input  dp_cmd_t          cmd,
    output out_item_t        result
);

    localparam int PW = $clog2(MAX_ITEMS + 1);
    localparam logic [PW-1:0] MAXP = PW'(MAX_ITEMS);

    logic [PW-1:0]         position_reg;
    logic [CNT_W-1:0]      pos_seen_reg, neg_seen_reg, pos_cut_reg, neg_cut_reg;
    logic [CNT_W-1:0]      pt_pos_reg, pt_neg_reg;
    logic [SCORE_BITS-1:0] prev_score_reg;
    logic [AREA_W-1:0]     area_reg;
    logic                  open_reg;        // a pending trapezoid product
    logic [AREA_W-1:0]     prod_reg;

    logic [SCORE_BITS-1:0] sc;
    logic                  live, is_pos, in_cut, change;
    logic [CNT_W-1:0]      dneg, psum;

    assign sc     = SCORE_BITS'(in_item.score);
    assign live   = position_reg < MAXP;
    assign is_pos = in_item.item_label == pos_label;
    assign in_cut = (position_reg == '0) || ({{(32-PW){1'b0}}, position_reg} <
                    {7'd0, ppc});
    assign change = (position_reg != '0) && (sc != prev_score_reg);
    assign dneg   = neg_seen_reg - pt_neg_reg;
    assign psum   = pt_pos_reg + pos_seen_reg;

    // divider
    logic [NUM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [15:0]      quo_reg;
    logic             sat_reg, zero_reg, err_reg;
    logic [2:0]       sel_reg;
    logic [DEN_W-1:0] auc_den_reg;
    logic             auc_ok_reg;
    logic [Q_W-1:0]   q_acc_reg, q_pre_reg, q_rec_reg, q_f1_reg, q_auc_reg;

    logic [CNT_W-1:0] fn, tn, tot;
    logic [NUM_W-1:0] n_sel;
    logic [DEN_W-1:0] d_sel;
    logic [NUM_W:0]   r2;

    assign fn  = pos_seen_reg - pos_cut_reg;
    assign tn  = neg_seen_reg - neg_cut_reg;
    assign tot = CNT_W'(position_reg);

    always_comb
    begin
        n_sel = '0;
        d_sel = '0;
        case (cmd.div_sel)
            SEL_ACC:
            begin
                n_sel = NUM_W'(pos_cut_reg) + NUM_W'(tn);
                d_sel = DEN_W'(tot);
            end
            SEL_PRE:
            begin
                n_sel = NUM_W'(pos_cut_reg);
                d_sel = DEN_W'(pos_cut_reg) + DEN_W'(neg_cut_reg);
            end
            SEL_REC:
            begin
                n_sel = NUM_W'(pos_cut_reg);
                d_sel = DEN_W'(pos_cut_reg) + DEN_W'(fn);
            end
            SEL_F1:
            begin
                n_sel = NUM_W'(pos_cut_reg) << 1;
                d_sel = (DEN_W'(pos_cut_reg) << 1) + DEN_W'(neg_cut_reg) + DEN_W'(fn);
            end
            default:
            begin
                n_sel = NUM_W'(area_reg);
                d_sel = auc_ok_reg ? auc_den_reg : '0;
            end
        endcase
    end

    assign r2 = {rem_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            pos_seen_reg   <= '0;
            neg_seen_reg   <= '0;
            pos_cut_reg    <= '0;
            neg_cut_reg    <= '0;
            pt_pos_reg     <= '0;
            pt_neg_reg     <= '0;
            prev_score_reg <= '0;
            area_reg       <= '0;
            open_reg       <= 1'b0;
            err_reg        <= 1'b0;
        end
        else if (cmd.clear)
        begin
            position_reg   <= '0;
            pos_seen_reg   <= '0;
            neg_seen_reg   <= '0;
            pos_cut_reg    <= '0;
            neg_cut_reg    <= '0;
            pt_pos_reg     <= '0;
            pt_neg_reg     <= '0;
            prev_score_reg <= '0;
            area_reg       <= '0;
            open_reg       <= 1'b0;
            err_reg        <= 1'b0;
        end
        else
        begin
            // product registered as a point opens folds into the area in the next cycle
            if (open_reg)
                area_reg <= area_reg + prod_reg;
            open_reg <= 1'b0;
            if (cmd.count && live)
            begin
                if (position_reg == '0 || change)
                    prev_score_reg <= sc;
                if (change)
                begin
                    open_reg   <= 1'b1;
                    pt_pos_reg <= pos_seen_reg;
                    pt_neg_reg <= neg_seen_reg;
                end
                if (is_pos)
                begin
                    pos_seen_reg <= pos_seen_reg + 1'b1;
                    if (in_cut)
                        pos_cut_reg <= pos_cut_reg + 1'b1;
                end
                else
                begin
                    neg_seen_reg <= neg_seen_reg + 1'b1;
                    if (in_cut)
                        neg_cut_reg <= neg_cut_reg + 1'b1;
                end
                position_reg <= position_reg + 1'b1;
            end
            if (cmd.close)
            begin
                open_reg   <= 1'b1;
                pt_pos_reg <= pos_seen_reg;
                pt_neg_reg <= neg_seen_reg;
            end
            if (cmd.div_start && d_sel == '0)
                err_reg <= 1'b1;
        end
    end

    // 25x25 product registered before accumulation
    always_ff @(posedge clk)
    begin
        prod_reg <= AREA_W'(dneg) * AREA_W'(psum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.den_mul)
        begin
            auc_ok_reg  <= (tot > ppc) && (ppc != '0);
            auc_den_reg <= DEN_W'(ppc) * DEN_W'(tot - ppc);
        end
        if (cmd.div_start)
        begin
            rem_reg  <= n_sel;
            den_reg  <= (cmd.div_sel == SEL_AUC) ? (d_sel << 1) : d_sel;
            quo_reg  <= '0;
            sel_reg  <= cmd.div_sel;
            zero_reg <= d_sel == '0;
            sat_reg  <= n_sel >= ((cmd.div_sel == SEL_AUC) ? (d_sel << 1) : d_sel);
        end
        else if (cmd.div_step)
        begin
            if (r2 >= {1'b0, den_reg})
            begin
                rem_reg <= NUM_W'(r2 - {1'b0, den_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= NUM_W'(r2);
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.div_store)
        begin
            case (sel_reg)
                SEL_ACC: q_acc_reg <= zero_reg ? '0 : sat_reg ? Q16_ONE : {1'b0, quo_reg};
                SEL_PRE: q_pre_reg <= zero_reg ? '0 : sat_reg ? Q16_ONE : {1'b0, quo_reg};
                SEL_REC: q_rec_reg <= zero_reg ? '0 : sat_reg ? Q16_ONE : {1'b0, quo_reg};
                SEL_F1:  q_f1_reg  <= zero_reg ? '0 : sat_reg ? Q16_ONE : {1'b0, quo_reg};
                default: q_auc_reg <= zero_reg ? '0 : sat_reg ? Q16_ONE : {1'b0, quo_reg};
            endcase
        end
    end

    assign result.true_pos      = pos_cut_reg;
    assign result.true_neg      = tn;
    assign result.false_pos     = neg_cut_reg;
    assign result.false_neg     = fn;
    assign result.item_total    = tot;
    assign result.accuracy_q16  = q_acc_reg;
    assign result.precision_q16 = q_pre_reg;
    assign result.recall_q16    = q_rec_reg;
    assign result.f1_q16        = q_f1_reg;
    assign result.auc_q16       = q_auc_reg;
    assign result.status        = err_reg;

endmodule

### rtl/core/rauc_ctrl.sv
module rauc_ctrl
    import rauc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [6:0]
    {
        S_RUN   = 7'b0000001,
        S_FOLD  = 7'b0000010,
        S_SUM   = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] sel_reg, sel_next;
    logic [3:0] step_reg, step_next;

    assign in_ready  = state_reg == S_RUN;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            S_RUN:
            begin
                cmd.count = in_valid;
                if (in_valid && sts.is_last)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                // pending product lands, then final point closes
                cmd.close  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.den_mul = 1'b1;
                state_next  = S_LOAD;
                sel_next    = SEL_ACC;
            end
            S_LOAD:
            begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == 4'd15)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.div_store = 1'b1;
                if (sel_reg == SEL_AUC)
                    state_next = S_OUT;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            sel_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/core/roc_auc_trapezoid.sv
// Throughput: one ranked item per cycle while streaming.
// On the last item: close the area and form 2*P*N, then run five
// Q1.16 divisions in turn on a shared restoring divider: the result
// appears once the last division is stored and holds till taken.
// Reset (rst_n, async, active low) clears all counters; config returns to 1/1.
module roc_auc_trapezoid
    import rauc_pkg::*;
#(
    parameter int MAX_ITEMS  = 16777216,
    parameter int SCORE_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CNT_W-1:0]  cfg_data
);

    logic [CNT_W-1:0] ppc_reg;
    logic [LBL_W-1:0] label_reg;
    dp_cmd_t          cmd;
    dp_sts_t          sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppc_reg   <= CNT_W'(1);
            label_reg <= LBL_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PPC:   ppc_reg   <= cfg_data;
                REG_LABEL: label_reg <= cfg_data[LBL_W-1:0];
                default:   ;
            endcase
        end
    end

    assign sts.is_last = in_data.is_last;

    rauc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rauc_datapath #(
        .SCORE_BITS (SCORE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .ppc       (ppc_reg),
        .pos_label (label_reg),
        .cmd       (cmd),
        .result    (out_data)
    );

endmodule

### rtl/core/rauc_checker.sv
module rauc_checker
    import rauc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // no new item while a result waits
    a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed");

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.auc_q16 <= Q16_ONE && out_data.f1_q16 <= Q16_ONE)
        else $error("ratio above one");

    a_conf_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> CNT_W'(out_data.true_pos + out_data.true_neg + out_data.false_pos
                      + out_data.false_neg) == out_data.item_total)
        else $error("confusion counts disagree with total");

endmodule

bind roc_auc_trapezoid rauc_checker u_rauc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
